// File: src/rbf_pkg.sv
// Shared types and constants for the ring buffer burst FIFO.
package rbf_pkg;

    localparam int CNT_W  = 7;
    localparam int WORD_W = 32;

    // Classified burst command handed from the front to the back.
    typedef struct packed {
        logic             is_read;
        logic [CNT_W-1:0] grant;
    } t_cmd;

endpackage

// File: src/rbf_front.sv
// Front end: accepts requests, clips them to space or occupancy, tracks occupancy.
module rbf_front
    import rbf_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_func,
    input  logic [CNT_W-1:0] i_request_count,
    output t_cmd             o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW = AW + 1;
    localparam int CW = (OW > CNT_W) ? OW : CNT_W;

    logic [OW-1:0]    r_occ;
    logic [OW-1:0]    n_occ;
    logic [CNT_W-1:0] req_sat;
    logic [OW-1:0]    avail;
    logic [CW-1:0]    grant_w;

    // Saturate the request, then clip it to what the buffer allows
    always_comb begin
        req_sat = (i_request_count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                         : i_request_count;
        avail   = i_func ? r_occ : (OW'(DEPTH) - r_occ);
        grant_w = (CW'(req_sat) < CW'(avail)) ? CW'(req_sat) : CW'(avail);
        o_cmd.is_read = i_func;
        o_cmd.grant   = CNT_W'(grant_w);
        n_occ = i_func ? OW'(CW'(r_occ) - grant_w) : OW'(CW'(r_occ) + grant_w);
    end

    // Advance the occupancy on every accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_accept) begin
            r_occ <= n_occ;
        end
    end

endmodule

// File: src/rbf_cmd_q.sv
// Two-entry command queue between the front and the back.
module rbf_cmd_q
    import rbf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_full,
    output logic o_empty
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_cmd   = r_slot[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/rbf_back.sv
// Back end: buffer storage, pointers, pattern source and result output register.
module rbf_back
    import rbf_pkg::*;
#(
    parameter int DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_was_read,
    output logic [CNT_W-1:0]  o_granted_count,
    output logic              o_word_valid,
    output logic [WORD_W-1:0] o_read_word,
    output logic              o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WRITE,
        S_READ
    } t_state;

    t_state            r_state;
    logic [AW-1:0]     r_rptr;
    logic [AW-1:0]     n_rptr;
    logic [AW-1:0]     r_wptr;
    logic [WORD_W-1:0] r_pattern;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_grant;
    logic [WORD_W-1:0] r_rdata;
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic              out_free;
    logic              rd_emit;

    assign out_free = !o_valid || !i_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_cmd_empty && out_free;
    assign rd_emit  = (r_state == S_READ) && out_free;
    assign n_rptr   = rd_emit ? ((r_rptr == LAST_IDX) ? '0 : r_rptr + AW'(1)) : r_rptr;

    // Write burst words and prefetch the word at the next read pointer
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_mem[r_wptr] <= r_pattern;
        end
        r_rdata <= r_mem[n_rptr];
    end

    // Sequence bursts and drive the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rptr    <= '0;
            r_wptr    <= '0;
            r_pattern <= '0;
            r_cnt     <= '0;
            r_grant   <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_rptr <= n_rptr;
            if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cnt   <= i_cmd.grant;
                        r_grant <= i_cmd.grant;
                        // Write bursts and empty grants answer at once
                        if (!i_cmd.is_read || i_cmd.grant == '0) begin
                            o_valid         <= 1'b1;
                            o_was_read      <= i_cmd.is_read;
                            o_granted_count <= i_cmd.grant;
                            o_word_valid    <= 1'b0;
                            o_read_word     <= '0;
                            o_last          <= 1'b1;
                        end
                        if (i_cmd.grant != '0) begin
                            r_state <= i_cmd.is_read ? S_READ : S_WRITE;
                        end
                    end
                end
                S_WRITE: begin
                    r_wptr    <= (r_wptr == LAST_IDX) ? '0 : r_wptr + AW'(1);
                    r_pattern <= r_pattern + WORD_W'(1);
                    r_cnt     <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (rd_emit) begin
                        o_valid         <= 1'b1;
                        o_was_read      <= 1'b1;
                        o_granted_count <= r_grant;
                        o_word_valid    <= 1'b1;
                        o_read_word     <= r_rdata;
                        o_last          <= (r_cnt == CNT_W'(1));
                        r_cnt           <= r_cnt - CNT_W'(1);
                        if (r_cnt == CNT_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/ring_buffer_burst_fifo.sv
// Top level of the ring buffer burst FIFO: front end, command queue and back end.
// On an idle block a write or empty result is registered when the back end pops its command
// from the queue; the first word of a read passes through the S_READ state to the output register.
// A burst moves one word per cycle (a read burst only while the output is not stalled), then
// the back end takes the next command in its idle state, where an empty grant is answered.
// Requests are taken while the two-entry command queue has room. Reset (synchronous,
// active low) empties the buffer and clears pointers and pattern.
module ring_buffer_burst_fifo
    import rbf_pkg::*;
#(
    parameter int DEPTH     = 1024,
    parameter int MAX_BURST = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [CNT_W-1:0]  i_request_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_was_read,
    output logic [CNT_W-1:0]  o_granted_count,
    output logic              o_word_valid,
    output logic [WORD_W-1:0] o_read_word,
    output logic              o_last
);

    t_cmd front_cmd;
    t_cmd head_cmd;
    logic q_full;
    logic q_empty;
    logic q_pop;
    logic accept;

    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    rbf_front #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_func          (i_func),
        .i_request_count (i_request_count),
        .o_cmd           (front_cmd)
    );

    rbf_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    rbf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_cmd_empty     (q_empty),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_was_read      (o_was_read),
        .o_granted_count (o_granted_count),
        .o_word_valid    (o_word_valid),
        .o_read_word     (o_read_word),
        .o_last          (o_last)
    );

endmodule

// File: src/rbf_chk.sv
// Port-level checker for the ring buffer burst FIFO and its bind.
module rbf_chk
    import rbf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic              o_was_read,
    input logic [CNT_W-1:0]  o_granted_count,
    input logic              o_word_valid,
    input logic [WORD_W-1:0] o_read_word,
    input logic              o_last
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_word) && $stable(o_last))
        else $error("stalled result changed");

    // Keep a read burst streaming until its last word
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_word_valid && !o_last |=> o_valid && o_word_valid)
        else $error("read burst broke off before its last word");

    // Give a single closing result for writes and empty grants
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (!o_was_read || o_granted_count == '0) |->
            !o_word_valid && o_last && o_read_word == '0)
        else $error("write or empty grant result malformed");

    // Never grant words to a read result without data
    a_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_read && o_granted_count != '0 |-> o_word_valid)
        else $error("granted read transfer without a word");

endmodule

bind ring_buffer_burst_fifo rbf_chk u_rbf_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_was_read      (o_was_read),
    .o_granted_count (o_granted_count),
    .o_word_valid    (o_word_valid),
    .o_read_word     (o_read_word),
    .o_last          (o_last)
);

// File: tb/tb.sv
// Self-checking testbench for the ring buffer burst FIFO.
`timescale 1ns / 100ps

module tb;
    import rbf_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int MAX_BURST  = 64;
    localparam int HOLD_LEN   = 400;
    localparam int HOLD_AT    = 60;
    localparam int RAND_ITEMS = 155;
    localparam int DRAIN      = 40;
    localparam int LIMIT      = 400000;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_READ  = 1'b1
    } t_func;

    typedef struct {
        t_func            fn;
        logic [CNT_W-1:0] cnt;
    } t_request;

    typedef struct {
        logic              was_read;
        logic [CNT_W-1:0]  granted_count;
        logic              word_valid;
        logic [WORD_W-1:0] read_word;
        logic              last;
    } t_beat;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_valid         = 1'b0;
    logic              o_stall;
    logic              i_func          = FUNC_WRITE;
    logic [CNT_W-1:0]  i_request_count = '0;
    logic              o_valid;
    logic              i_stall         = 1'b0;
    logic              o_was_read;
    logic [CNT_W-1:0]  o_granted_count;
    logic              o_word_valid;
    logic [WORD_W-1:0] o_read_word;
    logic              o_last;

    // Shadow of the buffer and its pointers
    logic [WORD_W-1:0] shadow_mem [DEPTH];
    int                shadow_rd;
    int                shadow_wr;
    logic              shadow_wrap;
    logic [WORD_W-1:0] shadow_pattern;

    t_request requests_q[$];
    t_beat    beats_due[$];
    t_request next_req;

    int burst_left;
    int gap_left;
    int stall_mode;
    int phase_left;
    int hold_left;
    bit hold_done;
    bit stall_next;

    int n_items;
    int n_writes;
    int n_reads;
    int n_beats;
    int n_zero;
    int n_wraps;
    int n_errors;
    int n_cycles;

    ring_buffer_burst_fifo #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_request_count (i_request_count),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_was_read      (o_was_read),
        .o_granted_count (o_granted_count),
        .o_word_valid    (o_word_valid),
        .o_read_word     (o_read_word),
        .o_last          (o_last)
    );

    // Clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Work out the beats one burst request produces and advance the shadow state
    task automatic predict_burst(input t_func fn, input logic [CNT_W-1:0] cnt);
        int    held;
        int    room;
        int    req;
        int    grant;
        t_beat b;
        held  = shadow_wrap ? DEPTH - shadow_rd + shadow_wr : shadow_wr - shadow_rd;
        req   = (cnt > MAX_BURST) ? MAX_BURST : int'(cnt);
        room  = (fn == FUNC_READ) ? held : DEPTH - held;
        grant = (req < room) ? req : room;
        b.was_read      = (fn == FUNC_READ);
        b.granted_count = grant[CNT_W-1:0];
        b.word_valid    = 1'b0;
        b.read_word     = '0;
        b.last          = 1'b1;
        if (grant == 0) begin
            n_zero++;
            beats_due.push_back(b);
        end else if (fn == FUNC_WRITE) begin
            for (int k = 0; k < grant; k++) begin
                shadow_mem[shadow_wr] = shadow_pattern;
                shadow_pattern        = shadow_pattern + 1'b1;
                shadow_wr++;
                if (shadow_wr == DEPTH) begin
                    shadow_wr   = 0;
                    shadow_wrap = 1'b1;
                    n_wraps++;
                end
            end
            beats_due.push_back(b);
        end else begin
            for (int k = 0; k < grant; k++) begin
                b.word_valid = 1'b1;
                b.read_word  = shadow_mem[shadow_rd];
                b.last       = (k == grant - 1);
                beats_due.push_back(b);
                shadow_rd++;
                if (shadow_rd == DEPTH) begin
                    shadow_rd   = 0;
                    shadow_wrap = 1'b0;
                    n_wraps++;
                end
            end
        end
    endtask

    function automatic t_request mk_req(input t_func fn, input int cnt);
        t_request r;
        r.fn  = fn;
        r.cnt = cnt[CNT_W-1:0];
        return r;
    endfunction

    // Driver: offer requests in bursts with gaps, hold payload while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid         <= 1'b0;
            i_func          <= FUNC_WRITE;
            i_request_count <= '0;
            burst_left      = 4;
            gap_left        = 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_burst(t_func'(i_func), i_request_count);
                n_items++;
                if (i_func == FUNC_READ) n_reads++;
                else n_writes++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (requests_q.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    next_req = requests_q.pop_front();
                    i_func          <= next_req.fn;
                    i_request_count <= next_req.cnt;
                    i_valid         <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: stall on a changing pattern, with one long hold-off to back up the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 1'b0;
            stall_mode = 0;
            phase_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else begin
            if (phase_left == 0) begin
                stall_mode = $urandom_range(2);
                phase_left = $urandom_range(20, 80);
            end else begin
                phase_left--;
            end
            case (stall_mode)
                0:       stall_next = 1'b0;
                1:       stall_next = 1'($urandom_range(1));
                default: stall_next = (phase_left % 4 == 0);
            endcase
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (!hold_done && n_items >= HOLD_AT) begin
                hold_left  = HOLD_LEN;
                hold_done  = 1'b1;
                stall_next = 1'b1;
            end
            i_stall <= stall_next;
        end
    end

    // Monitor: compare each result transfer with the oldest expected beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (beats_due.size() == 0) begin
                $error("unexpected result: was_read %0d granted_count %0d read_word %h",
                       o_was_read, o_granted_count, o_read_word);
                n_errors++;
            end else begin
                t_beat e;
                e = beats_due.pop_front();
                n_beats++;
                if (o_was_read !== e.was_read) begin
                    $error("was_read: expected %0d, actual %0d", e.was_read, o_was_read);
                    n_errors++;
                end
                if (o_granted_count !== e.granted_count) begin
                    $error("granted_count: expected %0d, actual %0d",
                           e.granted_count, o_granted_count);
                    n_errors++;
                end
                if (o_word_valid !== e.word_valid) begin
                    $error("word_valid: expected %0d, actual %0d", e.word_valid, o_word_valid);
                    n_errors++;
                end
                if (o_read_word !== e.read_word) begin
                    $error("read_word: expected %h, actual %h", e.read_word, o_read_word);
                    n_errors++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, actual %0d", e.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d beats outstanding",
                     n_cycles, beats_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int    wr_bias;
        int    phase_len;
        int    r;
        int    cnt;
        t_func fn;

        shadow_rd      = 0;
        shadow_wr      = 0;
        shadow_wrap    = 1'b0;
        shadow_pattern = '0;
        n_items  = 0;
        n_writes = 0;
        n_reads  = 0;
        n_beats  = 0;
        n_zero   = 0;
        n_wraps  = 0;
        n_errors = 0;
        n_cycles = 0;

        // Directed: zero counts, empty read, saturation, fill to full, write when full
        requests_q.push_back(mk_req(FUNC_WRITE, 0));
        requests_q.push_back(mk_req(FUNC_READ, 0));
        requests_q.push_back(mk_req(FUNC_WRITE, 1));
        requests_q.push_back(mk_req(FUNC_READ, 1));
        requests_q.push_back(mk_req(FUNC_WRITE, 127));
        requests_q.push_back(mk_req(FUNC_READ, 100));
        // Fill from an unaligned pointer so the write index crosses the end mid-burst
        for (int k = 0; k < 15; k++) requests_q.push_back(mk_req(FUNC_WRITE, 64));
        requests_q.push_back(mk_req(FUNC_WRITE, 127));
        requests_q.push_back(mk_req(FUNC_WRITE, 3));
        requests_q.push_back(mk_req(FUNC_READ, 127));
        requests_q.push_back(mk_req(FUNC_READ, 64));

        // Random: alternate write-heavy and read-heavy phases to reach full and empty
        wr_bias   = 80;
        phase_len = $urandom_range(10, 40);
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (phase_len == 0) begin
                r         = $urandom_range(2);
                wr_bias   = (r == 0) ? 80 : (r == 1) ? 20 : 50;
                phase_len = $urandom_range(10, 40);
            end else begin
                phase_len--;
            end
            fn = ($urandom_range(99) < wr_bias) ? FUNC_WRITE : FUNC_READ;
            r  = $urandom_range(99);
            if (r < 6) cnt = 0;
            else if (r < 14) cnt = $urandom_range(65, 127);
            else if (r < 30) cnt = $urandom_range(1, 4);
            else cnt = $urandom_range(1, 64);
            requests_q.push_back(mk_req(fn, cnt));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all requests to go in and all beats to come out
        while (requests_q.size() != 0 || i_valid) @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Covered %0d requests (%0d writes, %0d reads), %0d result beats checked.",
                 n_items, n_writes, n_reads, n_beats);
        $display("Zero grants: %0d, pointer wraps: %0d, long receiver hold-off: %0d.",
                 n_zero, n_wraps, hold_done);
        if (n_errors == 0 && beats_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
